### hdl/ternary_weight_dot_accumulate_defines.svh
// Assertion macros for the ternary weight dot accumulator.
// Used by the top level only; no other dependencies.
`ifndef TERNARY_WEIGHT_DOT_ACCUMULATE_DEFINES_SVH
`define TERNARY_WEIGHT_DOT_ACCUMULATE_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define TWDA_ASSERT_SAME(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define TWDA_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

### hdl/twda_pkg.sv
// Shared types and constants for the ternary weight dot accumulator.
// No dependencies.
package twda_pkg;

    localparam int CODE_W = 2;
    localparam int ACT_W  = 8;
    localparam int PROD_W = 10;
    localparam int ACC_W  = 32;

    typedef enum logic [CODE_W-1:0] {
        W_NEG  = 2'd0,
        W_ZERO = 2'd1,
        W_POS  = 2'd2,
        W_TWO  = 2'd3
    } t_wcode;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [ACC_W-1:0] prior;
    } t_ctl;

endpackage

### hdl/twda_lane.sv
// One lane: multiplies a signed activation by a weight code of -1, 0, 1 or 2.
// Depends on twda_pkg.
module twda_lane import twda_pkg::*; (
    input  logic                     i_clk,
    input  logic [CODE_W-1:0]        i_code,
    input  logic signed [ACT_W-1:0]  i_act,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] w_act;

    assign w_act = PROD_W'(i_act);

    always_comb begin
        case (t_wcode'(i_code))
            W_NEG:   n_prod = -w_act;
            W_ZERO:  n_prod = '0;
            W_POS:   n_prod = w_act;
            W_TWO:   n_prod = w_act <<< 1;
            default: n_prod = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

### hdl/twda_merge.sv
// Merge stage: adds the lane products, keeps the running row sum and forms
// the row result. Depends on twda_pkg.
module twda_merge import twda_pkg::*; #(
    parameter int LANES = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic signed [PROD_W-1:0] i_prod [LANES],
    input  t_ctl                     i_ctl,
    output logic                     o_wr,
    output logic [ACC_W-1:0]         o_wdata
);

    localparam int DOT_W = PROD_W + $clog2(LANES) + 1;

    logic signed [DOT_W-1:0] n_dot;
    logic signed [DOT_W-1:0] r_dot;
    t_ctl                    r_ctl2;
    t_ctl                    r_ctl3;
    logic [ACC_W-1:0]        r_total;
    logic [ACC_W-1:0]        n_total;
    logic [ACC_W-1:0]        w_base;
    logic                    r_clr;

    always_comb begin
        n_dot = '0;
        for (int i = 0; i < LANES; i++) begin
            n_dot = n_dot + DOT_W'(i_prod[i]);
        end
    end

    assign w_base  = (r_ctl2.first || r_clr) ? '0 : r_total;
    assign n_total = w_base + ACC_W'(r_dot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            r_clr  <= 1'b1;
        end else begin
            r_ctl2 <= i_ctl;
            r_ctl3 <= r_ctl2;
            if (r_ctl2.valid) begin
                r_clr <= r_ctl2.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dot <= n_dot;
        if (r_ctl2.valid) begin
            r_total <= n_total;
        end
    end

    assign o_wr    = r_ctl3.valid && r_ctl3.last;
    assign o_wdata = r_ctl3.prior + r_total;

endmodule

### hdl/twda_fifo.sv
// Result queue between the merge stage and the output stream.
// Depends on twda_pkg.
module twda_fifo import twda_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr,
    input  logic [ACC_W-1:0]           i_wdata,
    input  logic                       i_rd,
    output logic                       o_valid,
    output logic [ACC_W-1:0]           o_rdata,
    output logic [$clog2(DEPTH+1)-1:0] o_level
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [ACC_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [LVL_W-1:0] r_level;
    logic             w_rd;

    assign w_rd = i_rd && (r_level != '0);

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            case ({i_wr, w_rd})
                2'b10:   r_level <= r_level + LVL_W'(1);
                2'b01:   r_level <= r_level - LVL_W'(1);
                default: r_level <= r_level;
            endcase
        end
    end

    assign o_valid = (r_level != '0);
    assign o_rdata = r_mem[r_rptr];
    assign o_level = r_level;

endmodule

### hdl/ternary_weight_dot_accumulate.sv
// Ternary weight dot accumulator: four weight lanes, adder merge, row sum.
// Throughput: one item per cycle; the lane and merge pipeline never stalls,
// and s_axis_tready drops only while FIFO_DEPTH results are outstanding.
// Synchronous active-low reset empties the pipeline and queue, zeroes the row sum.
// Depends on twda_pkg, twda_lane, twda_merge, twda_fifo and the defines header.
`include "ternary_weight_dot_accumulate_defines.svh"

module ternary_weight_dot_accumulate import twda_pkg::*; #(
    parameter int  LANES      = 4,
    parameter int  FIFO_DEPTH = 8,
    localparam int S_TDATA_W  = ((CODE_W * LANES + ACT_W * LANES + ACC_W + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // weight_byte, act0 .. act(LANES-1), prior_acc, zero fill
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // first_of_row
    input  logic                 s_axis_tuser,
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // row_acc
    output logic [ACC_W-1:0]     m_axis_tdata
);

    localparam int WB_W  = CODE_W * LANES;
    localparam int PRI_L = WB_W + ACT_W * LANES;
    localparam int OUT_W = $clog2(FIFO_DEPTH + 1);

    logic                       w_in_hs;
    logic                       w_out_hs;
    logic signed [PROD_W-1:0]   w_prod [LANES];
    t_ctl                       r_ctl1;
    logic                       w_wr;
    logic [ACC_W-1:0]           w_wdata;
    logic [OUT_W-1:0]           r_outstanding;
    logic [OUT_W-1:0]           w_level;

    assign w_in_hs  = s_axis_tvalid && s_axis_tready;
    assign w_out_hs = m_axis_tvalid && m_axis_tready;

    assign s_axis_tready = (r_outstanding < OUT_W'(FIFO_DEPTH));

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        twda_lane u_lane (
            .i_clk  (i_clk),
            .i_code (s_axis_tdata[CODE_W*g +: CODE_W]),
            .i_act  (s_axis_tdata[WB_W + ACT_W*g +: ACT_W]),
            .o_prod (w_prod[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else begin
            r_ctl1.valid <= w_in_hs;
            r_ctl1.first <= s_axis_tuser;
            r_ctl1.last  <= s_axis_tlast;
            r_ctl1.prior <= s_axis_tdata[PRI_L +: ACC_W];
        end
    end

    twda_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_prod  (w_prod),
        .i_ctl   (r_ctl1),
        .o_wr    (w_wr),
        .o_wdata (w_wdata)
    );

    twda_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_wdata (w_wdata),
        .i_rd    (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_rdata (m_axis_tdata),
        .o_level (w_level)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            case ({w_in_hs && s_axis_tlast, w_out_hs})
                2'b10:   r_outstanding <= r_outstanding + OUT_W'(1);
                2'b01:   r_outstanding <= r_outstanding - OUT_W'(1);
                default: r_outstanding <= r_outstanding;
            endcase
        end
    end

    `TWDA_ASSERT_SAME(a_level_le_outstanding, i_clk, i_rst_n, 1'b1,
        w_level <= r_outstanding, "queue holds more results than outstanding")
    `TWDA_ASSERT_SAME(a_wr_has_room, i_clk, i_rst_n, w_wr,
        w_level < OUT_W'(FIFO_DEPTH) || w_out_hs, "queue written while full")
    `TWDA_ASSERT_NEXT(a_out_drains, i_clk, i_rst_n, w_out_hs && !(w_in_hs && s_axis_tlast),
        r_outstanding == $past(r_outstanding) - OUT_W'(1),
        "outstanding count not reduced by delivered item")

endmodule

### sim/testbench.sv
// Testbench for the ternary weight dot accumulator: streams packed weight/activation items,
// predicts each row result in step with accepted input and checks the output stream in order.
// Depends on twda_pkg and the ternary_weight_dot_accumulate top level.
module testbench import twda_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LANES      = 4;
    localparam int WB_W       = CODE_W * LANES;
    localparam int ACTS_W     = ACT_W * LANES;
    localparam int ACT_LO     = WB_W;
    localparam int PRIOR_LO   = WB_W + ACTS_W;
    localparam int TDATA_W    = ((WB_W + ACTS_W + ACC_W + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 3000;
    localparam int RX_HOLD    = 600;

    typedef struct {
        logic [WB_W-1:0]   wb;
        logic [ACTS_W-1:0] acts;
        logic              first;
        logic              last;
        logic [ACC_W-1:0]  prior;
        int unsigned       gap;
        bit                drain;
    } t_feed_item;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    // weight_byte, act0, act1, act2, act3, prior_acc
    logic [TDATA_W-1:0] s_axis_tdata = '0;
    // first_of_row
    logic               s_axis_tuser = 1'b0;
    // last_of_row
    logic               s_axis_tlast = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // row_acc
    logic [ACC_W-1:0]   m_axis_tdata;

    t_feed_item         byte_feed[$];
    t_feed_item         cur_item;
    int unsigned        gap_count;
    logic               drv_load;

    logic [ACC_W-1:0]   row_acc_due[$];
    logic [ACC_W-1:0]   row_sum_track;
    logic [ACC_W-1:0]   want_acc;
    int                 rows_owed = 0;
    int unsigned        items_in;
    int unsigned        results_out;
    int unsigned        rx_wait;
    int unsigned        hold_left;
    bit                 hold_done;
    int unsigned        fail_count = 0;
    int unsigned        idle_cycles = 0;

    ternary_weight_dot_accumulate dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2;
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
    end

    function automatic logic [ACC_W-1:0] byte_dot(input logic [WB_W-1:0] wb,
                                                 input logic [ACTS_W-1:0] acts);
        logic [ACC_W-1:0] total;
        logic [ACT_W-1:0] act8;
        logic [ACC_W-1:0] act32;
        t_wcode           code;
        total = '0;
        for (int k = 0; k < LANES; k++) begin
            code  = t_wcode'(wb[CODE_W*k +: CODE_W]);
            act8  = acts[ACT_W*k +: ACT_W];
            act32 = {{(ACC_W-ACT_W){act8[ACT_W-1]}}, act8};
            case (code)
                W_NEG:  total = total - act32;
                W_ZERO: ;
                W_POS:  total = total + act32;
                W_TWO:  total = total + (act32 << 1);
                default: ;
            endcase
        end
        return total;
    endfunction

    function automatic logic [ACT_W-1:0] pick_act();
        case ($urandom_range(0, 11))
            0: return 8'h80;
            1: return 8'h7F;
            2: return 8'h00;
            3: return 8'hFF;
            default: return ACT_W'($urandom);
        endcase
    endfunction

    function automatic logic [WB_W-1:0] pick_weights();
        case ($urandom_range(0, 11))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h55;
            3: return 8'hAA;
            default: return WB_W'($urandom);
        endcase
    endfunction

    function automatic logic [ACC_W-1:0] pick_prior();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic int unsigned draw_rx_wait();
        if ((results_out / 48) % 4 == 2) return 0;
        return $urandom_range(0, 13);
    endfunction

    task automatic add_item(input logic [WB_W-1:0] wb, input logic [ACTS_W-1:0] acts,
                            input logic first, input logic last,
                            input logic [ACC_W-1:0] prior, input bit drain = 1'b0);
        t_feed_item it;
        it.wb    = wb;
        it.acts  = acts;
        it.first = first;
        it.last  = last;
        it.prior = prior;
        it.drain = drain;
        it.gap   = ((byte_feed.size() / 64) % 4 == 1) ? 0 : $urandom_range(0, 13);
        byte_feed.push_back(it);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_count = 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            drv_load = 1'b0;
            if (byte_feed.size() != 0) begin
                if (byte_feed[0].drain && (s_axis_tvalid || rows_owed != 0)) begin
                    drv_load = 1'b0;
                end else if (gap_count < byte_feed[0].gap) begin
                    gap_count++;
                end else begin
                    cur_item  = byte_feed.pop_front();
                    gap_count = 0;
                    drv_load  = 1'b1;
                    s_axis_tdata <= TDATA_W'({cur_item.prior, cur_item.acts, cur_item.wb});
                    s_axis_tuser <= cur_item.first;
                    s_axis_tlast <= cur_item.last;
                end
            end
            s_axis_tvalid <= drv_load;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            row_sum_track = '0;
            row_acc_due.delete();
            rows_owed   <= 0;
            items_in    = 0;
            results_out = 0;
            hold_left   = 0;
            hold_done   = 1'b0;
            rx_wait     = $urandom_range(0, 13);
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                items_in++;
                if (s_axis_tuser) row_sum_track = '0;
                row_sum_track = row_sum_track + byte_dot(s_axis_tdata[WB_W-1:0],
                                                         s_axis_tdata[ACT_LO +: ACTS_W]);
                if (s_axis_tlast) begin
                    row_acc_due.push_back(s_axis_tdata[PRIOR_LO +: ACC_W] + row_sum_track);
                    row_sum_track = '0;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                results_out++;
                if (row_acc_due.size() == 0) begin
                    $error("row_acc: expected none, got %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    want_acc = row_acc_due.pop_front();
                    if (m_axis_tdata !== want_acc) begin
                        $error("row_acc: expected %h, got %h", want_acc, m_axis_tdata);
                        fail_count++;
                    end
                end
                rx_wait = draw_rx_wait();
            end
            rows_owed <= row_acc_due.size();
            if (!hold_done && items_in >= 700) begin
                hold_done = 1'b1;
                hold_left = RX_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_wait != 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        int unsigned row_len;
        bit          broken;
        logic        first;
        logic        last;
        bit          drain;
        int          drain_mark;

        add_item(8'h00, {4{8'h80}}, 1'b1, 1'b1, 32'h0000_0000);
        add_item(8'hFF, {4{8'h80}}, 1'b1, 1'b1, 32'h8000_0000);
        add_item(8'hFF, {4{8'h7F}}, 1'b1, 1'b1, 32'h7FFF_FFFF);
        add_item(8'h55, {4{8'h7F}}, 1'b1, 1'b1, 32'hFFFF_FFFF);
        add_item(8'hAA, {4{8'h7F}}, 1'b1, 1'b1, 32'h0000_0001);
        add_item(8'hE4, {8'h04, 8'h03, 8'h02, 8'h01}, 1'b1, 1'b1, 32'h0000_0000);
        add_item(8'hFF, {4{8'h7F}}, 1'b1, 1'b0, 32'hDEAD_BEEF);
        add_item(8'h00, {4{8'h80}}, 1'b0, 1'b0, 32'h1234_5678);
        add_item(8'hE4, {8'hFF, 8'h01, 8'h80, 8'h7F}, 1'b0, 1'b1, 32'h0000_0100);
        add_item(8'hAA, {4{8'h01}}, 1'b0, 1'b0, 32'h0000_0000);
        add_item(8'h1B, {8'h10, 8'h20, 8'h30, 8'h40}, 1'b0, 1'b1, 32'hFFFF_FF00);
        add_item(8'hFF, {4{8'h7F}}, 1'b1, 1'b0, 32'h0000_0000);
        add_item(8'hFF, {4{8'h7F}}, 1'b0, 1'b0, 32'hFFFF_FFFF);
        add_item(8'h00, {4{8'h80}}, 1'b1, 1'b1, 32'h0000_0000);
        add_item(8'h39, {8'h81, 8'h7E, 8'h01, 8'hFE}, 1'b0, 1'b1, 32'h8000_0000);
        add_item(8'h27, {8'hC3, 8'h5A, 8'hA5, 8'h3C}, 1'b1, 1'b1, 32'h8000_0001, 1'b1);

        drain_mark = 400;
        while (byte_feed.size() < 1800) begin
            row_len = $urandom_range(1, 8);
            if ($urandom_range(0, 15) == 0) row_len = $urandom_range(9, 40);
            broken = ($urandom_range(0, 9) == 0);
            drain  = 1'b0;
            if (byte_feed.size() >= drain_mark) begin
                drain      = 1'b1;
                drain_mark = drain_mark + 900;
            end
            for (int j = 0; j < row_len; j++) begin
                first = (j == 0);
                last  = (j == row_len - 1);
                if (broken) begin
                    first = 1'($urandom_range(0, 1));
                    last  = 1'($urandom_range(0, 1));
                end
                add_item(pick_weights(), {pick_act(), pick_act(), pick_act(), pick_act()},
                         first, last, pick_prior(), drain && (j == 0));
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(negedge i_clk);
        while (byte_feed.size() != 0 || s_axis_tvalid || rows_owed != 0);
        repeat (16) @(negedge i_clk);
        if (row_acc_due.size() != 0) begin
            $error("row_acc: %0d expected results never arrived", row_acc_due.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/twda_pkg.sv
hdl/twda_lane.sv
hdl/twda_merge.sv
hdl/twda_fifo.sv
hdl/ternary_weight_dot_accumulate.sv
sim/testbench.sv
